/* hw/rtl/sdsg_pkg.sv */
`default_nettype none
package sdsg_pkg;

    localparam int STRATA_X = 4;
    localparam int STRATA_Y = 8;
    localparam int TEX_SIZE = 8;
    localparam int GRID = STRATA_X * STRATA_Y;

    localparam int COL_W = $clog2(STRATA_X);
    localparam int ROW_W = $clog2(STRATA_Y);
    localparam int STRATUM_W = $clog2(GRID);

    localparam int SQRT_BITS = 31;
    localparam int CORDIC_STEPS = 24;
    // Input register, one root bit per stage, gain multiply, rotations, output.
    localparam int POINT_LAT = 1 + SQRT_BITS + 1 + CORDIC_STEPS + 1;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687, 30'd33543516, 30'd16775851, 30'd8388437,
        30'd4194283, 30'd2097149, 30'd1048576, 30'd524288,
        30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048,
        30'd1024, 30'd512, 30'd256, 30'd128
    };

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic [9:0]  addr;
        logic [31:0] phase0;
        logic [31:0] vq0;
        logic [31:0] phase1;
        logic [31:0] vq1;
    } q_word_t;

    function automatic logic [15:0] to_q15(input logic signed [34:0] v);
        logic signed [34:0] t;
        logic signed [19:0] r;
        logic [15:0] res;
        t = v + 35'sd16384;
        r = 20'(t >>> 15);
        if (r > 20'sd32767)
            res = 16'h7fff;
        else if (r < -20'sd32768)
            res = 16'h8000;
        else
            res = r[15:0];
        return res;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/stratified_disk_sample_gen.sv */
// Path from an accepted input word to its result word: front register, queue
// write, then 58 stages of input, root, gain multiply, rotation, output.
// Throughput: one word per cycle; the back pipeline halts as a whole only while
// a finished result is not taken, and the four-entry queue absorbs the front.
// Reset (rst_n, asynchronous, active low) clears all valid bits and pointers.
`default_nettype none
module stratified_disk_sample_gen
    import sdsg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pair_index[3:0], texel_col[6:4], texel_row[9:7], rand_u0[25:10],
    // rand_v0[41:26], rand_u1[57:42], rand_v1[73:58], zero fill [79:74]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // disk_x0[15:0], disk_y0[31:16], disk_x1[47:32], disk_y1[63:48],
    // texel_address[73:64], zero fill [79:74]
    output logic [79:0]      m_tdata
);

    logic    push, full, pop, empty;
    q_word_t push_word, head_word;
    logic [15:0] x0, y0, x1, y1;
    logic [9:0]  addr;

    sdsg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .pair_index (s_tdata[3:0]),
        .texel_col  (s_tdata[6:4]),
        .texel_row  (s_tdata[9:7]),
        .rand_u0    (s_tdata[25:10]),
        .rand_v0    (s_tdata[41:26]),
        .rand_u1    (s_tdata[57:42]),
        .rand_v1    (s_tdata[73:58]),
        .push       (push),
        .push_word  (push_word),
        .queue_full (full)
    );

    sdsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .head_word (head_word),
        .empty     (empty)
    );

    sdsg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_word     (head_word),
        .queue_empty   (empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .disk_x0       (x0),
        .disk_y0       (y0),
        .disk_x1       (x1),
        .disk_y1       (y1),
        .texel_address (addr)
    );

    assign m_tdata = {6'd0, addr, y1, x1, y0, x0};

endmodule
`default_nettype wire

/* hw/rtl/sdsg_front.sv */
`default_nettype none
module sdsg_front
    import sdsg_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [3:0]    pair_index,
    input  wire logic [2:0]    texel_col,
    input  wire logic [2:0]    texel_row,
    input  wire logic [15:0]   rand_u0,
    input  wire logic [15:0]   rand_v0,
    input  wire logic [15:0]   rand_u1,
    input  wire logic [15:0]   rand_v1,
    output logic               push,
    output q_word_t            push_word,
    input  wire logic          queue_full
);

    logic    valid_reg, valid_next;
    q_word_t word_reg;
    q_word_t word_next;
    logic    accept;

    function automatic logic [63:0] classify(input logic [3:0] pair, input logic k,
                                             input logic [15:0] ju,
                                             input logic [15:0] jv);
        logic [STRATUM_W-1:0] s;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [COL_W+31:0] pu;
        logic [ROW_W+31:0] pv;
        logic [31:0] phase;
        logic [31:0] vq;
        s = STRATUM_W'(({1'b0, pair, 1'b0} + {5'd0, k}) % GRID);
        col = COL_W'(s % STRATA_X);
        // Rows are counted down from the top of the grid.
        row = ROW_W'((GRID - 1 - int'(s)) / STRATA_X);
        pu = {col, ju, 16'd0};
        pv = {row, jv, 16'd0};
        phase = 32'(pu / STRATA_X);
        vq = 32'(pv / STRATA_Y);
        return {phase, vq};
    endfunction

    assign accept = in_valid && in_ready;
    assign in_ready = !valid_reg || !queue_full;
    assign push = valid_reg && !queue_full;
    assign push_word = word_reg;

    always_comb
    begin
        logic [63:0] p0;
        logic [63:0] p1;
        p0 = classify(pair_index, 1'b0, rand_u0, rand_v0);
        p1 = classify(pair_index, 1'b1, rand_u1, rand_v1);
        word_next.addr = 10'(int'(pair_index) * TEX_SIZE * TEX_SIZE
                             + int'(texel_row) * TEX_SIZE + int'(texel_col));
        word_next.phase0 = p0[63:32];
        word_next.vq0 = p0[31:0];
        word_next.phase1 = p1[63:32];
        word_next.vq1 = p1[31:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= word_next;
    end

endmodule
`default_nettype wire

/* hw/rtl/sdsg_queue.sv */
`default_nettype none
module sdsg_queue
    import sdsg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire q_word_t push_word,
    output logic         full,
    input  wire logic    pop,
    output q_word_t      head_word,
    output logic         empty
);

    q_word_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]      count_reg, count_next;

    assign full = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head_word = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_word;
    end

endmodule
`default_nettype wire

/* hw/rtl/sdsg_point.sv */
`default_nettype none
module sdsg_point
    import sdsg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] phase,
    input  wire logic [31:0] vq,
    output logic [15:0]      disk_x,
    output logic [15:0]      disk_y
);

    logic [63:0]        rem_reg  [SQRT_BITS+1];
    logic [30:0]        root_reg [SQRT_BITS+1];
    logic signed [33:0] zs_reg   [SQRT_BITS+1];
    logic [1:0]         qs_reg   [SQRT_BITS+1];

    logic signed [33:0] cx_reg [CORDIC_STEPS+1];
    logic signed [33:0] cy_reg [CORDIC_STEPS+1];
    logic signed [33:0] cz_reg [CORDIC_STEPS+1];
    logic [1:0]         cq_reg [CORDIC_STEPS+1];

    logic [15:0] x_reg, y_reg;
    logic [15:0] qx, qy;
    logic [60:0] zprod;
    logic [60:0] gprod;

    assign zprod = 61'(phase[29:0]) * 61'(HALF_PI_Q30);
    assign gprod = 61'(root_reg[SQRT_BITS]) * 61'(CORDIC_GAIN_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {2'b00, vq, 30'd0};
            root_reg[0] <= '0;
            zs_reg[0] <= $signed({3'b000, zprod[60:30]});
            qs_reg[0] <= phase[31:30];
        end
    end

    // Restoring square root, one result bit per stage, most significant first.
    for (genvar k = 0; k < SQRT_BITS; k++)
    begin : g_sqrt
        localparam int BIT = SQRT_BITS - 1 - k;
        logic [63:0] trial;
        assign trial = ({33'd0, root_reg[k]} << (BIT + 1)) | (64'd1 << (2 * BIT));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[k] >= trial)
                begin
                    rem_reg[k+1] <= rem_reg[k] - trial;
                    root_reg[k+1] <= root_reg[k] | (31'd1 << BIT);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
                zs_reg[k+1] <= zs_reg[k];
                qs_reg[k+1] <= qs_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= $signed({4'b0000, gprod[60:31]});
            cy_reg[0] <= '0;
            cz_reg[0] <= zs_reg[SQRT_BITS];
            cq_reg[0] <= qs_reg[SQRT_BITS];
        end
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_cordic
        logic signed [33:0] dx, dy, da;
        assign dx = cy_reg[j] >>> j;
        assign dy = cx_reg[j] >>> j;
        assign da = $signed({4'b0000, ATAN_TAB[j]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cz_reg[j] >= 0)
                begin
                    cx_reg[j+1] <= cx_reg[j] - dx;
                    cy_reg[j+1] <= cy_reg[j] + dy;
                    cz_reg[j+1] <= cz_reg[j] - da;
                end
                else
                begin
                    cx_reg[j+1] <= cx_reg[j] + dx;
                    cy_reg[j+1] <= cy_reg[j] - dy;
                    cz_reg[j+1] <= cz_reg[j] + da;
                end
                cq_reg[j+1] <= cq_reg[j];
            end
        end
    end

    always_comb
    begin
        logic signed [34:0] c, s, rx, ry;
        c = 35'(cx_reg[CORDIC_STEPS]);
        s = 35'(cy_reg[CORDIC_STEPS]);
        unique case (cq_reg[CORDIC_STEPS])
            2'd0:
            begin
                rx = c;
                ry = s;
            end
            2'd1:
            begin
                rx = -s;
                ry = c;
            end
            2'd2:
            begin
                rx = -c;
                ry = -s;
            end
            default:
            begin
                rx = s;
                ry = -c;
            end
        endcase
        qx = to_q15(rx);
        qy = to_q15(ry);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= qx;
            y_reg <= qy;
        end
    end

    assign disk_x = x_reg;
    assign disk_y = y_reg;

endmodule
`default_nettype wire

/* hw/rtl/sdsg_back.sv */
`default_nettype none
module sdsg_back
    import sdsg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_word_t head_word,
    input  wire logic    queue_empty,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output logic [15:0]  disk_x0,
    output logic [15:0]  disk_y0,
    output logic [15:0]  disk_x1,
    output logic [15:0]  disk_y1,
    output logic [9:0]   texel_address
);

    logic       vld_reg  [POINT_LAT];
    logic [9:0] addr_reg [POINT_LAT];
    logic       adv;
    logic [15:0] px0, py0, px1, py1;

    // The whole pipeline moves together; it halts only while a result waits.
    assign adv = !vld_reg[POINT_LAT-1] || out_ready;
    assign pop = adv && !queue_empty;

    sdsg_point u_point0 (
        .clk    (clk),
        .en     (adv),
        .phase  (head_word.phase0),
        .vq     (head_word.vq0),
        .disk_x (px0),
        .disk_y (py0)
    );

    sdsg_point u_point1 (
        .clk    (clk),
        .en     (adv),
        .phase  (head_word.phase1),
        .vq     (head_word.vq1),
        .disk_x (px1),
        .disk_y (py1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POINT_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= !queue_empty;
            for (int i = 1; i < POINT_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_reg[0] <= head_word.addr;
            for (int i = 1; i < POINT_LAT; i++)
                addr_reg[i] <= addr_reg[i-1];
        end
    end

    assign out_valid = vld_reg[POINT_LAT-1];
    assign texel_address = addr_reg[POINT_LAT-1];
    assign disk_x0 = px0;
    assign disk_y0 = py0;
    assign disk_x1 = px1;
    assign disk_y1 = py1;

endmodule
`default_nettype wire

/* hw/rtl/sdsg_checker.sv */
`default_nettype none
module sdsg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);

    // A result waiting on the master side keeps its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[79:74] == 6'd0)
        else $error("fill bits of result word not zero");

    // Nothing comes out in the cycle after reset; the pipeline starts empty.
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    // The front takes a word when nothing in the front register waits or the queue has room.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> s_tready)
        else $error("not ready after reset");

endmodule

bind stratified_disk_sample_gen sdsg_checker u_sdsg_checker (.*);
`default_nettype wire
